### hdl/text_cell_glyph_rasterizer_unit_defines.svh
// Assertion macros for the text cell glyph rasterizer checker.
// Needs clk and rst in scope where they are used.
`ifndef TEXT_CELL_GLYPH_RASTERIZER_UNIT_DEFINES_SVH
`define TEXT_CELL_GLYPH_RASTERIZER_UNIT_DEFINES_SVH

// Same-cycle implication, off during reset.
`define TCGR_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcgr check failed");

// Next-cycle implication, off during reset.
`define TCGR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcgr check failed");

// Next-cycle implication that also holds across reset.
`define TCGR_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tcgr check failed");

`endif

### hdl/tcgr_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and colour tables for the glyph rasterizer.
// No dependencies.
package tcgr_pkg;

  localparam int MAX_CELL_WIDTH  = 16;
  localparam int MAX_CELL_HEIGHT = 32;
  localparam int FONT_WIDTH      = 8;
  localparam int FONT_HEIGHT     = 16;

  localparam int COL_W    = 8;
  localparam int LINE_W   = 8;
  localparam int ROW_W    = 5;
  localparam int GLYPH_W  = 16;
  localparam int GI_W     = $clog2(GLYPH_W);
  localparam int IDX_W    = 4;
  localparam int FMT_W    = 2;
  localparam int STRIDE_W = 15;
  localparam int CW_W     = 5;
  localparam int CH_W     = 6;
  localparam int CLIP_W   = 14;
  localparam int OFF_W    = 27;
  localparam int PIX_W    = 24;
  localparam int BPP_W    = 3;
  localparam int CFG_W    = 15;
  localparam int CNT_W    = (MAX_CELL_WIDTH > 1) ? $clog2(MAX_CELL_WIDTH) : 1;
  localparam int X_W      = COL_W + CW_W;
  localparam int Y_W      = LINE_W + CH_W;
  localparam int XB_W     = X_W + 2;
  localparam int YS_W     = Y_W + STRIDE_W;

  localparam logic [FMT_W-1:0] FMT_RGB565 = 2'd0;
  localparam logic [FMT_W-1:0] FMT_RGB24  = 2'd1;
  localparam logic [FMT_W-1:0] FMT_RGB32  = 2'd2;

  typedef enum logic [2:0] {
    REG_PIXEL_FORMAT = 3'd0,
    REG_LINE_STRIDE  = 3'd1,
    REG_CELL_WIDTH   = 3'd2,
    REG_CELL_HEIGHT  = 3'd3,
    REG_CLIP_LEFT    = 3'd4,
    REG_CLIP_TOP     = 3'd5,
    REG_CLIP_RIGHT   = 3'd6,
    REG_CLIP_BOTTOM  = 3'd7
  } reg_idx_t;

  localparam logic [FMT_W-1:0]    RST_PIXEL_FORMAT = FMT_RGB32;
  localparam logic [STRIDE_W-1:0] RST_LINE_STRIDE  = 15'd4096;
  localparam logic [CW_W-1:0]     RST_CELL_WIDTH   = 5'd8;
  localparam logic [CH_W-1:0]     RST_CELL_HEIGHT  = 6'd16;
  localparam logic [CLIP_W-1:0]   RST_CLIP_LEFT    = 14'd0;
  localparam logic [CLIP_W-1:0]   RST_CLIP_TOP     = 14'd0;
  localparam logic [CLIP_W-1:0]   RST_CLIP_RIGHT   = 14'd1023;
  localparam logic [CLIP_W-1:0]   RST_CLIP_BOTTOM  = 14'd767;

  // 0xRRGGBB
  localparam logic [PIX_W-1:0] PALETTE [16] = '{
    24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
    24'hAA0000, 24'hAA00AA, 24'hAA5500, 24'hAAAAAA,
    24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
    24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF
  };

  // Same palette scaled to RGB565, channels truncated
  localparam logic [15:0] PALETTE_565 [16] = '{
    16'h0000, 16'h0014, 16'h0540, 16'h0554,
    16'hA000, 16'hA014, 16'hA2A0, 16'hA554,
    16'h52AA, 16'h52BF, 16'h57EA, 16'h57FF,
    16'hFAAA, 16'hFABF, 16'hFFEA, 16'hFFFF
  };

  typedef struct packed {
    logic [COL_W-1:0]   cell_column;
    logic [LINE_W-1:0]  cell_line;
    logic [ROW_W-1:0]   row_in_cell;
    logic [GLYPH_W-1:0] glyph_bits;
    logic [IDX_W-1:0]   fg_color;
    logic [IDX_W-1:0]   bg_color;
  } tcgr_in_t;

  typedef struct packed {
    logic               write_enable;
    logic [OFF_W-1:0]   byte_offset;
    logic [PIX_W-1:0]   pixel_value;
    logic [BPP_W-1:0]   bytes_per_pixel;
    logic               last_of_row;
  } tcgr_out_t;

  typedef struct packed {
    logic [FMT_W-1:0]    pixel_format;
    logic [STRIDE_W-1:0] line_stride;
    logic [CW_W-1:0]     cell_width;
    logic [CH_W-1:0]     cell_height;
    logic [CLIP_W-1:0]   clip_left;
    logic [CLIP_W-1:0]   clip_top;
    logic [CLIP_W-1:0]   clip_right;
    logic [CLIP_W-1:0]   clip_bottom;
  } tcgr_cfg_t;

  // One glyph row, ready for column expansion
  typedef struct packed {
    logic               empty;
    logic [CW_W-1:0]    w;
    logic [X_W-1:0]     x_base;
    logic [OFF_W-1:0]   ystride;
    logic               y_in;
    logic               row_ok;
    logic [GLYPH_W-1:0] glyph;
    logic [PIX_W-1:0]   fgv;
    logic [PIX_W-1:0]   bgv;
  } tcgr_item_t;

  // One column of a glyph row
  typedef struct packed {
    logic             empty;
    logic [X_W-1:0]   x;
    logic [OFF_W-1:0] ystride;
    logic             y_in;
    logic [PIX_W-1:0] pix;
    logic             last;
  } tcgr_col_t;

  function automatic logic [BPP_W-1:0] bpp_of(input logic [FMT_W-1:0] fmt);
    logic [BPP_W-1:0] b;
    case (fmt)
      FMT_RGB565: b = 3'd2;
      FMT_RGB24:  b = 3'd3;
      default:    b = 3'd4;
    endcase
    return b;
  endfunction

  function automatic logic [PIX_W-1:0] pack_colour(input logic [IDX_W-1:0] idx,
                                                   input logic [FMT_W-1:0] fmt);
    logic [PIX_W-1:0] c;
    logic [PIX_W-1:0] v;
    c = PALETTE[idx];
    if (fmt == FMT_RGB565) begin
      v = PIX_W'(PALETTE_565[idx]);
    end else begin
      v = {c[7:0], c[15:8], c[23:16]};
    end
    return v;
  endfunction

endpackage

### hdl/tcgr_item.sv
`timescale 1ns / 1ps
// Per-row front end: cell geometry, colours, then y * stride and vertical clip.
// Depends on tcgr_pkg.
module tcgr_item (
  input  logic                  clk,
  input  logic                  rst,
  input  tcgr_pkg::tcgr_cfg_t   cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tcgr_pkg::tcgr_in_t    in_data,
  output logic                  item_valid,
  input  logic                  item_ready,
  output tcgr_pkg::tcgr_item_t  item
);
  import tcgr_pkg::*;

  typedef struct packed {
    logic               empty;
    logic [CW_W-1:0]    w;
    logic [X_W-1:0]     x_base;
    logic [Y_W-1:0]     y;
    logic               row_ok;
    logic [GLYPH_W-1:0] glyph;
    logic [PIX_W-1:0]   fgv;
    logic [PIX_W-1:0]   bgv;
  } stage_a_t;

  logic [CW_W-1:0] w_sat;
  logic [CH_W-1:0] h_sat;
  logic            a_valid;
  logic            a_adv;
  stage_a_t        a_q;
  stage_a_t        a_next;
  logic            b_valid;
  logic            b_adv;
  tcgr_item_t      b_q;
  tcgr_item_t      b_next;
  logic [YS_W-1:0] ys_full;

  always_comb begin
    w_sat = (int'(cfg.cell_width) > MAX_CELL_WIDTH) ? CW_W'(MAX_CELL_WIDTH) : cfg.cell_width;
    h_sat = (int'(cfg.cell_height) > MAX_CELL_HEIGHT) ? CH_W'(MAX_CELL_HEIGHT)
                                                      : cfg.cell_height;
    a_next.empty  = (w_sat == '0) || (CH_W'(in_data.row_in_cell) >= h_sat);
    a_next.w      = w_sat;
    a_next.x_base = X_W'(in_data.cell_column) * X_W'(w_sat);
    a_next.y      = Y_W'(in_data.cell_line) * Y_W'(h_sat) + Y_W'(in_data.row_in_cell);
    a_next.row_ok = int'(in_data.row_in_cell) < FONT_HEIGHT;
    a_next.glyph  = in_data.glyph_bits;
    a_next.fgv    = pack_colour(in_data.fg_color, cfg.pixel_format);
    a_next.bgv    = pack_colour(in_data.bg_color, cfg.pixel_format);
  end

  always_comb begin
    ys_full        = YS_W'(a_q.y) * YS_W'(cfg.line_stride);
    b_next.empty   = a_q.empty;
    b_next.w       = a_q.w;
    b_next.x_base  = a_q.x_base;
    b_next.ystride = ys_full[OFF_W-1:0];
    b_next.y_in    = (int'(a_q.y) >= int'(cfg.clip_top)) &&
                     (int'(a_q.y) <= int'(cfg.clip_bottom));
    b_next.row_ok  = a_q.row_ok;
    b_next.glyph   = a_q.glyph;
    b_next.fgv     = a_q.fgv;
    b_next.bgv     = a_q.bgv;
  end

  assign b_adv      = !b_valid || item_ready;
  assign a_adv      = !a_valid || b_adv;
  assign in_ready   = a_adv;
  assign item_valid = b_valid;
  assign item       = b_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (a_adv) begin
        a_valid <= in_valid;
      end
      if (b_adv) begin
        b_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && in_valid) begin
      a_q <= a_next;
    end
    if (b_adv && a_valid) begin
      b_q <= b_next;
    end
  end

endmodule

### hdl/tcgr_seq.sv
`timescale 1ns / 1ps
// Column sequencer: expands a glyph row, one column per ready cycle.
// Depends on tcgr_pkg.
module tcgr_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  tcgr_pkg::tcgr_item_t  item,
  output logic                  col_valid,
  input  logic                  col_ready,
  output tcgr_pkg::tcgr_col_t   col
);
  import tcgr_pkg::*;

  logic             it_v;
  tcgr_item_t       it;
  logic [CNT_W-1:0] cnt;
  logic             col_fire;
  logic             col_last;
  logic [GI_W-1:0]  gidx;
  logic             on;

  always_comb begin
    col_last   = it.empty || (CW_W'(cnt) + CW_W'(1) == it.w);
    col_fire   = it_v && col_ready;
    item_ready = !it_v || (col_fire && col_last);
    gidx       = GI_W'(GLYPH_W - 1 - int'(cnt));
    on         = it.row_ok && (int'(cnt) < FONT_WIDTH) && (int'(cnt) < GLYPH_W) &&
                 it.glyph[gidx];
    col.empty   = it.empty;
    col.x       = it.x_base + X_W'(cnt);
    col.ystride = it.ystride;
    col.y_in    = it.y_in;
    col.pix     = on ? it.fgv : it.bgv;
    col.last    = col_last;
  end

  assign col_valid = it_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      it_v <= 1'b0;
      cnt  <= '0;
    end else if (item_ready) begin
      it_v <= item_valid;
      cnt  <= '0;
    end else if (col_fire) begin
      cnt  <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      it <= item;
    end
  end

endmodule

### hdl/tcgr_pix.sv
`timescale 1ns / 1ps
// Per-pixel back end: x * bpp and horizontal clip, then offset add into output register.
// Depends on tcgr_pkg.
module tcgr_pix (
  input  logic                 clk,
  input  logic                 rst,
  input  tcgr_pkg::tcgr_cfg_t  cfg,
  input  logic                 col_valid,
  output logic                 col_ready,
  input  tcgr_pkg::tcgr_col_t  col,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tcgr_pkg::tcgr_out_t  out_data
);
  import tcgr_pkg::*;

  typedef struct packed {
    logic             empty;
    logic             we;
    logic [XB_W-1:0]  xb;
    logic [OFF_W-1:0] ystride;
    logic [PIX_W-1:0] pix;
    logic             last;
  } stage_p_t;

  logic       p_valid;
  logic       p_adv;
  logic       o_adv;
  logic       x_in;
  stage_p_t   p_q;
  stage_p_t   p_next;
  tcgr_out_t  o_q;
  tcgr_out_t  o_next;

  always_comb begin
    x_in = (int'(col.x) >= int'(cfg.clip_left)) && (int'(col.x) <= int'(cfg.clip_right));
    case (cfg.pixel_format)
      FMT_RGB565: p_next.xb = XB_W'(col.x) << 1;
      FMT_RGB24:  p_next.xb = XB_W'(col.x) + (XB_W'(col.x) << 1);
      default:    p_next.xb = XB_W'(col.x) << 2;
    endcase
    p_next.empty   = col.empty;
    p_next.we      = !col.empty && x_in && col.y_in;
    p_next.ystride = col.ystride;
    p_next.pix     = col.empty ? '0 : col.pix;
    p_next.last    = col.last;
  end

  always_comb begin
    o_next.write_enable    = p_q.we;
    o_next.byte_offset     = p_q.empty ? '0 : p_q.ystride + OFF_W'(p_q.xb);
    o_next.pixel_value     = p_q.pix;
    o_next.bytes_per_pixel = bpp_of(cfg.pixel_format);
    o_next.last_of_row     = p_q.last;
  end

  assign o_adv     = !out_valid || out_ready;
  assign p_adv     = !p_valid || o_adv;
  assign col_ready = p_adv;
  assign out_data  = o_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (p_adv) begin
        p_valid <= col_valid;
      end
      if (o_adv) begin
        out_valid <= p_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p_adv && col_valid) begin
      p_q <= p_next;
    end
    if (o_adv && p_valid) begin
      o_q <= o_next;
    end
  end

endmodule

### hdl/text_cell_glyph_rasterizer_unit.sv
`timescale 1ns / 1ps
// Top level of the text cell glyph rasterizer: configuration registers and pipeline.
// Depends on tcgr_pkg, tcgr_item, tcgr_seq, tcgr_pix.
//
//   channel | signals                         | transfer
//   --------+---------------------------------+-------------------------------
//   input   | in_valid, in_ready, in_data     | one glyph row per transaction
//   output  | out_valid, out_ready, out_data  | one pixel write per transaction
//   config  | cfg_write, cfg_index, cfg_data  | one register write per cycle
//
// One pixel per cycle unless stalled: cell_width per row (capped at 16), one if empty.
// The column sequencer sets that rate; a new row enters while the previous one drains.
// Registers from input to first pixel: stage A, stage B, sequencer, stage P, output.
// Synchronous reset clears all valid flags and restores the register defaults.
// A stall on the output holds every stage in place; nothing is dropped or repeated.
module text_cell_glyph_rasterizer_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tcgr_pkg::tcgr_in_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tcgr_pkg::tcgr_out_t           out_data,
  input  logic                          cfg_write,
  input  tcgr_pkg::reg_idx_t            cfg_index,
  input  logic [tcgr_pkg::CFG_W-1:0]    cfg_data
);
  import tcgr_pkg::*;

  tcgr_cfg_t  cfg;
  logic       item_valid;
  logic       item_ready;
  tcgr_item_t item;
  logic       col_valid;
  logic       col_ready;
  tcgr_col_t  col;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_format <= RST_PIXEL_FORMAT;
      cfg.line_stride  <= RST_LINE_STRIDE;
      cfg.cell_width   <= RST_CELL_WIDTH;
      cfg.cell_height  <= RST_CELL_HEIGHT;
      cfg.clip_left    <= RST_CLIP_LEFT;
      cfg.clip_top     <= RST_CLIP_TOP;
      cfg.clip_right   <= RST_CLIP_RIGHT;
      cfg.clip_bottom  <= RST_CLIP_BOTTOM;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PIXEL_FORMAT: cfg.pixel_format <= cfg_data[FMT_W-1:0];
        REG_LINE_STRIDE:  cfg.line_stride  <= cfg_data[STRIDE_W-1:0];
        REG_CELL_WIDTH:   cfg.cell_width   <= cfg_data[CW_W-1:0];
        REG_CELL_HEIGHT:  cfg.cell_height  <= cfg_data[CH_W-1:0];
        REG_CLIP_LEFT:    cfg.clip_left    <= cfg_data[CLIP_W-1:0];
        REG_CLIP_TOP:     cfg.clip_top     <= cfg_data[CLIP_W-1:0];
        REG_CLIP_RIGHT:   cfg.clip_right   <= cfg_data[CLIP_W-1:0];
        REG_CLIP_BOTTOM:  cfg.clip_bottom  <= cfg_data[CLIP_W-1:0];
      endcase
    end
  end

  tcgr_item u_item (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  tcgr_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .col_valid  (col_valid),
    .col_ready  (col_ready),
    .col        (col)
  );

  tcgr_pix u_pix (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .col_valid (col_valid),
    .col_ready (col_ready),
    .col       (col),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### hdl/tcgr_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the glyph rasterizer, bound to the top level.
// Depends on tcgr_pkg and text_cell_glyph_rasterizer_unit_defines.svh.
`include "text_cell_glyph_rasterizer_unit_defines.svh"

module tcgr_chk (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_ready,
  input tcgr_pkg::tcgr_out_t  out_data
);
  import tcgr_pkg::*;

  logic bpp_ok;
  logic is_565;

  assign bpp_ok = (out_data.bytes_per_pixel == 3'd2) || (out_data.bytes_per_pixel == 3'd3) ||
                  (out_data.bytes_per_pixel == 3'd4);
  assign is_565 = out_data.bytes_per_pixel == 3'd2;

  `TCGR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `TCGR_ASSERT(a_bpp_legal, out_valid, bpp_ok)
  `TCGR_ASSERT(a_565_upper, out_valid && is_565, out_data.pixel_value[PIX_W-1:16] == '0)
  `TCGR_ASSERT_RST(a_rst_idle, rst, !out_valid)

endmodule

bind text_cell_glyph_rasterizer_unit tcgr_chk u_tcgr_chk (.*);

### tb/sv/text_cell_glyph_rasterizer_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for text_cell_glyph_rasterizer_unit: glyph rows in, pixel writes out.
// Predicts every pixel write from its own copy of the registers and palette; uses tcgr_pkg.
module text_cell_glyph_rasterizer_unit_tb;
  import tcgr_pkg::*;

  localparam logic [FMT_W-1:0] FMT_SPARE = 2'd3;

  // 0xRRGGBB
  localparam logic [23:0] vga_rgb [16] = '{
    24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
    24'hAA0000, 24'hAA00AA, 24'hAA5500, 24'hAAAAAA,
    24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
    24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  tcgr_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tcgr_out_t out_data;
  logic cfg_write = 1'b0;
  reg_idx_t cfg_index = REG_PIXEL_FORMAT;
  logic [CFG_W-1:0] cfg_data = '0;

  tcgr_cfg_t cfg_now;
  tcgr_out_t pending_pixels[$];
  int mismatches = 0;
  bit gaps_on = 1'b0;
  bit stalls_on = 1'b0;
  int hold_left = 0;

  text_cell_glyph_rasterizer_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

  // mostly short pauses, now and then a long one
  function automatic int pick_pause(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int unsigned bytes_of(input logic [FMT_W-1:0] fmt);
    case (fmt)
      FMT_RGB565: return 2;
      FMT_RGB24:  return 3;
      default:    return 4;
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] colour_of(input logic [IDX_W-1:0] idx,
                                                 input logic [FMT_W-1:0] fmt);
    logic [23:0] rgb;
    int unsigned r, g, b;
    rgb = vga_rgb[idx];
    r = 32'(rgb[23:16]);
    g = 32'(rgb[15:8]);
    b = 32'(rgb[7:0]);
    if (fmt == FMT_RGB565) begin
      return PIX_W'(((r * 31 / 255) << 11) | ((g * 63 / 255) << 5) | (b * 31 / 255));
    end
    return {rgb[7:0], rgb[15:8], rgb[23:16]};
  endfunction

  function automatic void expand_glyph_row(input tcgr_in_t row);
    int unsigned w, h, bpp, x, y, c;
    logic [63:0] off;
    logic [PIX_W-1:0] fgv, bgv;
    logic lit;
    tcgr_out_t px;
    w = 32'(cfg_now.cell_width);
    h = 32'(cfg_now.cell_height);
    bpp = bytes_of(cfg_now.pixel_format);
    if (w > MAX_CELL_WIDTH) w = MAX_CELL_WIDTH;
    if (h > MAX_CELL_HEIGHT) h = MAX_CELL_HEIGHT;
    if (w == 0 || row.row_in_cell >= h) begin
      px = '0;
      px.bytes_per_pixel = BPP_W'(bpp);
      px.last_of_row = 1'b1;
      pending_pixels.push_back(px);
      return;
    end
    fgv = colour_of(row.fg_color, cfg_now.pixel_format);
    bgv = colour_of(row.bg_color, cfg_now.pixel_format);
    y = row.cell_line * h + row.row_in_cell;
    for (c = 0; c < w; c++) begin
      x = row.cell_column * w + c;
      lit = row.row_in_cell < FONT_HEIGHT && c < FONT_WIDTH && row.glyph_bits[15 - c];
      px.write_enable = x >= cfg_now.clip_left && x <= cfg_now.clip_right &&
                        y >= cfg_now.clip_top && y <= cfg_now.clip_bottom;
      off = 64'(y) * cfg_now.line_stride + 64'(x) * bpp;
      px.byte_offset = off[OFF_W-1:0];
      px.pixel_value = lit ? fgv : bgv;
      px.bytes_per_pixel = BPP_W'(bpp);
      px.last_of_row = (c + 1 == w);
      pending_pixels.push_back(px);
    end
  endfunction

  function automatic tcgr_in_t mk_row(input int col, input int line, input int row,
                                      input int glyph, input int fg, input int bg);
    tcgr_in_t t;
    t.cell_column = COL_W'(col);
    t.cell_line = LINE_W'(line);
    t.row_in_cell = ROW_W'(row);
    t.glyph_bits = GLYPH_W'(glyph);
    t.fg_color = IDX_W'(fg);
    t.bg_color = IDX_W'(bg);
    return t;
  endfunction

  function automatic tcgr_cfg_t default_setting();
    tcgr_cfg_t c;
    c.pixel_format = RST_PIXEL_FORMAT;
    c.line_stride = RST_LINE_STRIDE;
    c.cell_width = RST_CELL_WIDTH;
    c.cell_height = RST_CELL_HEIGHT;
    c.clip_left = RST_CLIP_LEFT;
    c.clip_top = RST_CLIP_TOP;
    c.clip_right = RST_CLIP_RIGHT;
    c.clip_bottom = RST_CLIP_BOTTOM;
    return c;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("%0t ns: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) hold_left <= pick_pause(stalls_on);
    end
  end

  always @(posedge clk) begin : check_pixels
    tcgr_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("pixel write with none pending", 64'(out_data), 64'(0));
      end else begin
        want = pending_pixels.pop_front();
        if (out_data.write_enable !== want.write_enable)
          report_mismatch("write_enable", 64'(out_data.write_enable),
                          64'(want.write_enable));
        if (out_data.byte_offset !== want.byte_offset)
          report_mismatch("byte_offset", 64'(out_data.byte_offset),
                          64'(want.byte_offset));
        if (out_data.pixel_value !== want.pixel_value)
          report_mismatch("pixel_value", 64'(out_data.pixel_value),
                          64'(want.pixel_value));
        if (out_data.bytes_per_pixel !== want.bytes_per_pixel)
          report_mismatch("bytes_per_pixel", 64'(out_data.bytes_per_pixel),
                          64'(want.bytes_per_pixel));
        if (out_data.last_of_row !== want.last_of_row)
          report_mismatch("last_of_row", 64'(out_data.last_of_row),
                          64'(want.last_of_row));
      end
    end
  end

  task automatic push_glyph_row(input tcgr_in_t row);
    int gap;
    gap = pick_pause(gaps_on);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= row;
    do @(posedge clk); while (!in_ready);
    expand_glyph_row(row);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_reg(input reg_idx_t idx, input logic [CFG_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic apply_config(input tcgr_cfg_t c);
    wait_idle();
    set_reg(REG_PIXEL_FORMAT, CFG_W'(c.pixel_format));
    set_reg(REG_LINE_STRIDE, CFG_W'(c.line_stride));
    set_reg(REG_CELL_WIDTH, CFG_W'(c.cell_width));
    set_reg(REG_CELL_HEIGHT, CFG_W'(c.cell_height));
    set_reg(REG_CLIP_LEFT, CFG_W'(c.clip_left));
    set_reg(REG_CLIP_TOP, CFG_W'(c.clip_top));
    set_reg(REG_CLIP_RIGHT, CFG_W'(c.clip_right));
    set_reg(REG_CLIP_BOTTOM, CFG_W'(c.clip_bottom));
    cfg_write <= 1'b0;
    @(posedge clk);
    cfg_now = c;
  endtask

  task automatic test_default_setting();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    apply_config(default_setting());
    push_glyph_row(mk_row(0, 0, 0, 16'hFFFF, 15, 0));
    // last column and row inside the default clip
    push_glyph_row(mk_row(127, 47, 15, 16'h0000, 0, 15));
    push_glyph_row(mk_row(128, 48, 0, 16'h8001, 5, 10));
    push_glyph_row(mk_row(255, 255, 31, 16'hFFFF, 15, 15));
    push_glyph_row(mk_row(3, 2, 16, 16'hC3C3, 7, 8));
  endtask

  task automatic test_pixel_formats();
    tcgr_cfg_t c;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    c = default_setting();
    c.pixel_format = FMT_RGB565;
    apply_config(c);
    for (int i = 0; i < 8; i++) begin
      push_glyph_row(mk_row(i, i, i, 16'hAAAA ^ i, 2 * i, 2 * i + 1));
    end
    c.pixel_format = FMT_RGB24;
    apply_config(c);
    push_glyph_row(mk_row(9, 4, 3, 16'h55AA, 12, 9));
    c.pixel_format = FMT_SPARE;
    apply_config(c);
    push_glyph_row(mk_row(10, 5, 2, 16'h3C00, 14, 6));
  endtask

  task automatic test_cell_geometry();
    tcgr_cfg_t c;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    c = default_setting();
    c.cell_width = 5'd16;
    c.cell_height = 6'd32;
    apply_config(c);
    push_glyph_row(mk_row(20, 10, 20, 16'hFFFF, 13, 1));
    push_glyph_row(mk_row(21, 10, 15, 16'h0F0F, 11, 4));
    c.cell_width = 5'd31;
    c.cell_height = 6'd63;
    apply_config(c);
    push_glyph_row(mk_row(30, 11, 31, 16'hF00F, 2, 3));
    c.cell_width = 5'd0;
    apply_config(c);
    push_glyph_row(mk_row(1, 1, 0, 16'hFFFF, 15, 0));
    c.cell_width = 5'd1;
    c.cell_height = 6'd1;
    apply_config(c);
    push_glyph_row(mk_row(200, 250, 0, 16'h8000, 9, 2));
    push_glyph_row(mk_row(200, 250, 1, 16'h8000, 9, 2));
    c.cell_width = 5'd8;
    c.cell_height = 6'd0;
    apply_config(c);
    push_glyph_row(mk_row(4, 4, 0, 16'hFF00, 10, 5));
  endtask

  task automatic test_clip_and_wrap();
    tcgr_cfg_t c;
    gaps_on = 1'b0;
    stalls_on = 1'b1;
    c = default_setting();
    c.clip_left = 14'd17;
    c.clip_right = 14'd21;
    c.clip_top = 14'd5;
    c.clip_bottom = 14'd5;
    apply_config(c);
    push_glyph_row(mk_row(2, 0, 5, 16'hA5A5, 14, 1));
    push_glyph_row(mk_row(2, 0, 6, 16'hA5A5, 14, 1));
    // offset beyond 27 bits
    c.line_stride = 15'h7FFF;
    c.cell_width = 5'd16;
    c.cell_height = 6'd32;
    c.clip_left = '0;
    c.clip_top = '0;
    c.clip_right = 14'h3FFF;
    c.clip_bottom = 14'h3FFF;
    apply_config(c);
    push_glyph_row(mk_row(255, 255, 31, 16'h1234, 3, 12));
  endtask

  function automatic tcgr_cfg_t rand_setting();
    tcgr_cfg_t c;
    c.pixel_format = FMT_W'($urandom_range(0, 3));
    case ($urandom_range(0, 4))
      0: c.line_stride = '0;
      1: c.line_stride = 15'h7FFF;
      default: c.line_stride = STRIDE_W'($urandom_range(0, 16384));
    endcase
    c.cell_width = ($urandom_range(0, 9) < 8) ? CW_W'($urandom_range(1, 16))
                                              : CW_W'($urandom_range(0, 31));
    c.cell_height = ($urandom_range(0, 9) < 8) ? CH_W'($urandom_range(1, 32))
                                               : CH_W'($urandom_range(0, 63));
    if ($urandom_range(0, 4) == 0) begin
      c.clip_left = '0;
      c.clip_top = '0;
      c.clip_right = 14'h3FFF;
      c.clip_bottom = 14'h3FFF;
    end else begin
      c.clip_left = CLIP_W'($urandom_range(0, 1500));
      c.clip_right = CLIP_W'($urandom_range(0, 4500));
      c.clip_top = CLIP_W'($urandom_range(0, 3000));
      c.clip_bottom = CLIP_W'($urandom_range(0, 9000));
    end
    return c;
  endfunction

  task automatic test_random_rows();
    tcgr_in_t t;
    int unsigned h;
    for (int phase = 0; phase < 5; phase++) begin
      gaps_on = (phase != 0);
      stalls_on = (phase != 0) && (phase != 3);
      apply_config(rand_setting());
      h = (cfg_now.cell_height > MAX_CELL_HEIGHT) ? MAX_CELL_HEIGHT
                                                  : 32'(cfg_now.cell_height);
      for (int n = 0; n < 40; n++) begin
        t.cell_column = COL_W'($urandom());
        t.cell_line = LINE_W'($urandom());
        if (h > 0 && $urandom_range(0, 9) < 8)
          t.row_in_cell = ROW_W'($urandom_range(0, h - 1));
        else
          t.row_in_cell = ROW_W'($urandom());
        case ($urandom_range(0, 9))
          0: t.glyph_bits = '0;
          1: t.glyph_bits = '1;
          default: t.glyph_bits = GLYPH_W'($urandom());
        endcase
        t.fg_color = IDX_W'($urandom());
        t.bg_color = IDX_W'($urandom());
        push_glyph_row(t);
      end
    end
  endtask

  initial begin
    cfg_now = default_setting();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_default_setting();
    test_pixel_formats();
    test_cell_geometry();
    test_clip_and_wrap();
    test_random_rows();
    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
